>>> sv/fra_pkg.sv
// Package for the fragment reassembler: shared constants, codes and types.
// No dependencies; imported by every module of the block.
`default_nettype none

package fra_pkg;

  localparam int unsigned FragWords  = 8;
  localparam int unsigned FragBytes  = FragWords * 8;
  localparam int unsigned WifW       = (FragWords > 1) ? $clog2(FragWords) : 1;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);
  localparam int unsigned AddrW      = 3;
  localparam logic [15:0] CapReset   = 16'hFFFF;

  typedef enum logic [1:0] {
    CmdWord    = 2'd0,
    CmdTimeout = 2'd1,
    CmdStart   = 2'd2,
    CmdRsvd    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CauseNone    = 2'd0,
    CauseTimeout = 2'd1,
    CauseOrder   = 2'd2,
    CauseSize    = 2'd3
  } cause_e;

  typedef enum logic [0:0] {
    RegCapacity = 1'b0,
    RegRsvd     = 1'b1
  } reg_e;

  typedef struct packed {
    logic        write_valid;
    logic [12:0] write_offset;
    logic [63:0] write_data;
    logic        message_done;
    logic [15:0] message_length;
    logic        aborted;
    cause_e      abort_cause;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

>>> sv/fra_front.sv
// Front end of the fragment reassembler: accepts items, tracks the session
// and classifies each word. Depends on fra_pkg.
`default_nettype none

module fra_front
  import fra_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  message_id_i,
  input  wire logic [7:0]  packet_number_i,
  input  wire logic        more_follow_i,
  input  wire logic [63:0] payload_word_i,
  input  wire logic [15:0] capacity_i,
  output res_t             res_o,
  output logic             push_o
);

  logic            active_q, active_d;
  logic            known_q, known_d;
  logic [7:0]      exp_msg_q, exp_msg_d;
  logic [7:0]      exp_pkt_q, exp_pkt_d;
  logic [15:0]     bytes_q, bytes_d;
  logic [WifW-1:0] wif_q, wif_d;
  logic            drop_q, drop_d;
  logic            last_q, last_d;

  logic [7:0]      exp_v;
  logic [15:0]     bytes_v;
  logic [15:0]     bytes_n;
  logic            drop_v;
  logic            last_v;
  logic            abort_v;
  cause_e          cause_v;
  logic            final_w;
  logic [16:0]     need;

  always_comb begin
    active_d = active_q;
    known_d  = known_q;
    exp_msg_d = exp_msg_q;
    exp_pkt_d = exp_pkt_q;
    bytes_d  = bytes_q;
    wif_d    = wif_q;
    drop_d   = drop_q;
    last_d   = last_q;
    res_o    = '0;
    push_o   = 1'b0;
    exp_v    = exp_pkt_q;
    bytes_v  = bytes_q;
    drop_v   = drop_q;
    last_v   = last_q;
    abort_v  = 1'b0;
    cause_v  = CauseNone;
    final_w  = (wif_q == WifW'(FragWords - 1));
    bytes_n  = 16'd0;
    need     = 17'd0;
    if (accept_i) begin
      unique case (cmd_e'(command_i))
        CmdStart: begin
          active_d  = 1'b1;
          known_d   = 1'b0;
          exp_pkt_d = 8'd0;
          bytes_d   = 16'd0;
          wif_d     = '0;
          drop_d    = 1'b0;
          last_d    = 1'b0;
        end
        CmdTimeout: begin
          if (active_q) begin
            abort_v = 1'b1;
            cause_v = CauseTimeout;
          end
        end
        CmdWord: begin
          if (active_q) begin
            if (wif_q == '0) begin
              if (!known_q || message_id_i != exp_msg_q) begin
                known_d   = 1'b1;
                exp_msg_d = message_id_i;
                exp_v     = 8'd0;
                bytes_v   = 16'd0;
              end
              need = {1'b0, bytes_v} + 17'(FragBytes);
              if (packet_number_i < exp_v) begin
                drop_v = 1'b1;
              end else if (packet_number_i > exp_v) begin
                abort_v = 1'b1;
                cause_v = CauseOrder;
              end else if (need > {1'b0, capacity_i}) begin
                abort_v = 1'b1;
                cause_v = CauseSize;
              end else begin
                drop_v = 1'b0;
                last_v = !more_follow_i;
              end
            end
            exp_pkt_d = exp_v;
            bytes_d   = bytes_v;
            if (!abort_v) begin
              wif_d  = final_w ? '0 : wif_q + WifW'(1);
              drop_d = drop_v;
              last_d = last_v;
              if (!drop_v) begin
                bytes_n            = bytes_v + 16'd8;
                push_o             = 1'b1;
                res_o.write_valid  = 1'b1;
                res_o.write_offset = bytes_v[15:3];
                res_o.write_data   = payload_word_i;
                bytes_d            = bytes_n;
                if (final_w) begin
                  exp_pkt_d = exp_v + 8'd1;
                  if (last_v) begin
                    res_o.message_done   = 1'b1;
                    res_o.message_length = bytes_n;
                    active_d             = 1'b0;
                  end
                end
              end else if (final_w) begin
                drop_d = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
      if (abort_v) begin
        push_o            = 1'b1;
        res_o.aborted     = 1'b1;
        res_o.abort_cause = cause_v;
        active_d          = 1'b0;
        wif_d             = '0;
        drop_d            = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      known_q   <= 1'b0;
      exp_msg_q <= 8'd0;
      exp_pkt_q <= 8'd0;
      bytes_q   <= 16'd0;
      wif_q     <= '0;
      drop_q    <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      active_q  <= active_d;
      known_q   <= known_d;
      exp_msg_q <= exp_msg_d;
      exp_pkt_q <= exp_pkt_d;
      bytes_q   <= bytes_d;
      wif_q     <= wif_d;
      drop_q    <= drop_d;
      last_q    <= last_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/fra_queue.sv
// Short result queue between the front and back ends of the reassembler.
// Depends on fra_pkg.
`default_nettype none

module fra_queue
  import fra_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  res_t      wdata_i,
  input  wire logic pop_i,
  output res_t      head_o,
  output q_stat_t   stat_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    stat_o.empty = (cnt_q == '0);
    stat_o.full  = (cnt_q == QCntW'(QDepth));
    head_o       = mem_q[rd_q];
    wr_d         = push_i ? wr_q + QPtrW'(1) : wr_q;
    rd_d         = pop_i ? rd_q + QPtrW'(1) : rd_q;
    cnt_d        = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/fra_back.sv
// Back end of the reassembler: moves queued results into the output register.
// Depends on fra_pkg.
`default_nettype none

module fra_back
  import fra_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  res_t      head_i,
  input  q_stat_t   stat_i,
  output logic      pop_o,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output res_t      out_o
);

  logic out_valid_q, out_valid_d;
  res_t out_q;

  always_comb begin
    pop_o       = !stat_i.empty && (!out_valid_q || out_ready_i);
    out_valid_d = pop_o || (out_valid_q && !out_ready_i);
    out_valid_o = out_valid_q;
    out_o       = out_q;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/fragment_reassembler_unit.sv
// Top level of the fragment reassembler: APB register, front end, result
// queue and output stage. Depends on fra_pkg, fra_front, fra_queue, fra_back.
//
//   channel | handshake               | payload
//   in      | in_valid_i / in_ready_o | command, message_id, packet_number,
//           |                         | more_follow, payload_word
//   out     | out_valid_o/out_ready_i | write_*, message_done, message_length,
//           |                         | aborted, abort_cause
//   cfg     | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied high)
//
// One item per cycle; an item's result is written into the result queue and
// then moved into the output register. A four-entry queue sits between the
// front end and the output register, so input stalls only once it is full.
// Reset clears the session and sets buffer_capacity to 65535.
`default_nettype none

module fragment_reassembler_unit
  import fra_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       command_i,
  input  wire logic [7:0]       message_id_i,
  input  wire logic [7:0]       packet_number_i,
  input  wire logic             more_follow_i,
  input  wire logic [63:0]      payload_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  write_valid_o,
  output logic [12:0]           write_offset_o,
  output logic [63:0]           write_data_o,
  output logic                  message_done_o,
  output logic [15:0]           message_length_o,
  output logic                  aborted_o,
  output logic [1:0]            abort_cause_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0] cap_q, cap_d;
  logic        cfg_wr;
  reg_e        reg_sel;
  logic        accept;
  logic        push;
  logic        pop;
  res_t        front_res;
  res_t        head;
  res_t        out_res;
  q_stat_t     qstat;

  always_comb begin
    pready  = 1'b1;
    reg_sel = reg_e'(paddr[2]);
    cfg_wr  = psel && penable && pwrite;
    cap_d   = cap_q;
    prdata  = 32'd0;
    unique case (reg_sel)
      RegCapacity: begin
        prdata = {16'd0, cap_q};
        if (cfg_wr) begin
          cap_d = pwdata[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign in_ready_o = !qstat.full;
  assign accept     = in_valid_i && in_ready_o;

  fra_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .command_i       (command_i),
    .message_id_i    (message_id_i),
    .packet_number_i (packet_number_i),
    .more_follow_i   (more_follow_i),
    .payload_word_i  (payload_word_i),
    .capacity_i      (cap_q),
    .res_o           (front_res),
    .push_o          (push)
  );

  fra_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_res),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (qstat)
  );

  fra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_res)
  );

  assign write_valid_o    = out_res.write_valid;
  assign write_offset_o   = out_res.write_offset;
  assign write_data_o     = out_res.write_data;
  assign message_done_o   = out_res.message_done;
  assign message_length_o = out_res.message_length;
  assign aborted_o        = out_res.aborted;
  assign abort_cause_o    = out_res.abort_cause;

endmodule

`default_nettype wire

>>> sv/fra_checker.sv
// Port-level checks for the fragment reassembler, bound to the top level.
// Depends on fra_pkg and fragment_reassembler_unit.
`default_nettype none

module fra_checker
  import fra_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        write_valid_o,
  input wire logic [12:0] write_offset_o,
  input wire logic [63:0] write_data_o,
  input wire logic        message_done_o,
  input wire logic [15:0] message_length_o,
  input wire logic        aborted_o,
  input wire logic [1:0]  abort_cause_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(write_data_o)
      && $stable(write_offset_o) && $stable(abort_cause_o))
    else $error("output item changed while stalled");

  a_abort_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && aborted_o |-> !write_valid_o && !message_done_o
      && abort_cause_o != CauseNone)
    else $error("abort mixed with a write");

  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_done_o |->
      write_valid_o && message_length_o == ({write_offset_o, 3'b000} + 16'd8))
    else $error("message length does not match last offset");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> write_data_o == 64'd0
      && write_offset_o == 13'd0 && message_length_o == 16'd0)
    else $error("non-write item carries write fields");

endmodule

bind fragment_reassembler_unit fra_checker u_fra_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .write_valid_o    (write_valid_o),
  .write_offset_o   (write_offset_o),
  .write_data_o     (write_data_o),
  .message_done_o   (message_done_o),
  .message_length_o (message_length_o),
  .aborted_o        (aborted_o),
  .abort_cause_o    (abort_cause_o)
);

`default_nettype wire

>>> bench/tb_fragment_reassembler_unit.sv
// Self-checking bench for fragment_reassembler_unit: fragments, restarts, duplicates and aborts,
// predicted in-bench and checked per result, under random idling and capacity changes over APB.
// Depends on fra_pkg and the fragment_reassembler_unit RTL.
`default_nettype none

module tb_fragment_reassembler_unit import fra_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned PhaseItems  = 145;
  localparam int unsigned NumPhases   = 7;
  localparam logic [AddrW-1:0] CapAddr = AddrW'(4 * int'(RegCapacity));

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  msg_id;
    logic [7:0]  pkt_num;
    logic        more;
    logic [63:0] data;
  } frag_item_t;

  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             in_valid_i       = 1'b0;
  logic             in_ready_o;
  logic [1:0]       command_i        = '0;
  logic [7:0]       message_id_i     = '0;
  logic [7:0]       packet_number_i  = '0;
  logic             more_follow_i    = 1'b0;
  logic [63:0]      payload_word_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i      = 1'b0;
  logic             write_valid_o;
  logic [12:0]      write_offset_o;
  logic [63:0]      write_data_o;
  logic             message_done_o;
  logic [15:0]      message_length_o;
  logic             aborted_o;
  logic [1:0]       abort_cause_o;
  logic             psel             = 1'b0;
  logic             penable          = 1'b0;
  logic             pwrite           = 1'b0;
  logic [AddrW-1:0] paddr            = '0;
  logic [31:0]      pwdata           = '0;
  logic [31:0]      prdata;
  logic             pready;

  fragment_reassembler_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .message_id_i     (message_id_i),
    .packet_number_i  (packet_number_i),
    .more_follow_i    (more_follow_i),
    .payload_word_i   (payload_word_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .write_valid_o    (write_valid_o),
    .write_offset_o   (write_offset_o),
    .write_data_o     (write_data_o),
    .message_done_o   (message_done_o),
    .message_length_o (message_length_o),
    .aborted_o        (aborted_o),
    .abort_cause_o    (abort_cause_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  frag_item_t  words_to_send[$];
  res_t        results_due[$];
  frag_item_t  tx_item;
  res_t        predicted;
  res_t        seen_res;
  res_t        due_res;
  int unsigned errors        = 0;
  int unsigned items_queued  = 0;
  int unsigned tx_gap        = 0;
  int unsigned rx_gap        = 0;
  int unsigned rx_hold       = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_gap_pct  = 0;
  int unsigned recv_gap_pct  = 0;
  bit          idle_en       = 1'b1;

  // reassembly state as the block should hold it
  logic [15:0] capacity   = CapReset;
  bit          rd_active  = 1'b0;
  bit          id_known   = 1'b0;
  logic [7:0]  cur_msg_id = '0;
  logic [7:0]  next_pkt   = '0;
  logic [15:0] bytes_done = '0;
  int unsigned word_idx   = 0;
  bit          skip_dup   = 1'b0;
  bit          last_frag  = 1'b0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic bit abort_read(inout res_t r, input cause_e cause);
    r.aborted     = 1'b1;
    r.abort_cause = cause;
    rd_active     = 1'b0;
    word_idx      = 0;
    skip_dup      = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit reassemble(input frag_item_t it, output res_t r);
    bit last_word;
    r = '0;
    if (it.cmd == CmdStart) begin
      rd_active  = 1'b1;
      id_known   = 1'b0;
      next_pkt   = '0;
      bytes_done = '0;
      word_idx   = 0;
      skip_dup   = 1'b0;
      last_frag  = 1'b0;
      return 1'b0;
    end
    if (it.cmd == CmdRsvd || !rd_active) return 1'b0;
    if (it.cmd == CmdTimeout) return abort_read(r, CauseTimeout);
    if (word_idx == 0) begin
      if (!id_known || it.msg_id != cur_msg_id) begin
        id_known   = 1'b1;
        cur_msg_id = it.msg_id;
        next_pkt   = '0;
        bytes_done = '0;
      end
      if (it.pkt_num < next_pkt) begin
        skip_dup = 1'b1;
      end else if (it.pkt_num > next_pkt) begin
        return abort_read(r, CauseOrder);
      end else if (17'(bytes_done) + 17'(FragBytes) > 17'(capacity)) begin
        return abort_read(r, CauseSize);
      end else begin
        skip_dup  = 1'b0;
        last_frag = !it.more;
      end
    end
    last_word = (word_idx + 1 >= FragWords);
    word_idx  = last_word ? 0 : word_idx + 1;
    if (skip_dup) begin
      if (last_word) skip_dup = 1'b0;
      return 1'b0;
    end
    r.write_valid  = 1'b1;
    r.write_offset = bytes_done[15:3];
    r.write_data   = it.data;
    bytes_done     = bytes_done + 16'd8;
    if (last_word) begin
      next_pkt = next_pkt + 8'd1;
      if (last_frag) begin
        r.message_done   = 1'b1;
        r.message_length = bytes_done;
        rd_active        = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("wr=%0b off=%0d data=%h done=%0b len=%0d abort=%0b cause=%0d",
                     r.write_valid, r.write_offset, r.write_data, r.message_done,
                     r.message_length, r.aborted, r.abort_cause);
  endfunction

  // driver: predict on accept, then load the next item or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (reassemble(tx_item, predicted)) results_due = {results_due, predicted};
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (words_to_send.size() > 0) begin
          tx_item = words_to_send.pop_front();
          command_i       <= tx_item.cmd;
          message_id_i    <= tx_item.msg_id;
          packet_number_i <= tx_item.pkt_num;
          more_follow_i   <= tx_item.more;
          payload_word_i  <= tx_item.data;
          in_valid_i      <= 1'b1;
          if (idle_en && $urandom_range(0, 99) < send_gap_pct) tx_gap = $urandom_range(1, 13);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check against the oldest expectation, then set ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen_res = {write_valid_o, write_offset_o, write_data_o, message_done_o,
                    message_length_o, aborted_o, abort_cause_o};
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %s", show(seen_res));
        end else begin
          due_res = results_due.pop_front();
          if (seen_res !== due_res) begin
            errors++;
            if (errors <= 10) begin
              $display("result mismatch: expected %s", show(due_res));
              $display("                 actual   %s", show(seen_res));
            end
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_en && $urandom_range(0, 99) < recv_gap_pct) rx_gap = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("fragment_reassembler_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_item(input cmd_e cmd, input logic [7:0] id, input logic [7:0] pkt,
                          input logic more, input logic [63:0] data);
    frag_item_t it;
    it            = '{cmd, id, pkt, more, data};
    words_to_send = {words_to_send, it};
    items_queued++;
  endtask

  task automatic send_fragment(input logic [7:0] id, input logic [7:0] pkt,
                               input logic more, input int unsigned n_words);
    for (int unsigned w = 0; w < n_words; w++) begin
      if (w == 0) add_item(CmdWord, id, pkt, more, rand_word());
      else add_item(CmdWord, 8'($urandom), 8'($urandom), 1'($urandom), rand_word());
    end
  endtask

  task automatic send_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      add_item(cmd_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 1'($urandom),
               rand_word());
    end
  endtask

  task automatic send_message(input int unsigned max_frags);
    logic [7:0]  id;
    int unsigned pkt;
    int unsigned frags;
    int unsigned roll;
    if ($urandom_range(0, 9) != 0) begin
      add_item(CmdStart, 8'($urandom), 8'($urandom), 1'($urandom), rand_word());
    end
    id    = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    pkt   = 0;
    frags = $urandom_range(1, max_frags);
    for (int unsigned f = 0; f < frags; f++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10 && pkt > 0) begin
        send_fragment(id, 8'($urandom_range(0, pkt - 1)), 1'($urandom), FragWords);
      end else if (roll < 14) begin
        send_fragment(id, 8'(pkt + $urandom_range(1, 3)), 1'b1, FragWords);
        return;
      end else if (roll < 17) begin
        add_item(CmdTimeout, 8'($urandom), 8'($urandom), 1'($urandom), rand_word());
        return;
      end else if (roll < 20) begin
        id  = 8'($urandom);
        pkt = 0;
      end else if (roll < 22) begin
        send_fragment(id, 8'(pkt), 1'b1, $urandom_range(1, FragWords - 1));
        return;
      end
      send_fragment(id, 8'(pkt), (f != frags - 1) || ($urandom_range(0, 19) == 0), FragWords);
      pkt++;
    end
  endtask

  task automatic queue_directed();
    add_item(CmdWord, 8'hFF, 8'hFF, 1'b1, '1);
    add_item(CmdTimeout, '0, '0, 1'b0, '0);
    add_item(CmdRsvd, 8'hFF, 8'hFF, 1'b1, '1);
    add_item(CmdStart, '0, '0, 1'b0, '0);
    add_item(CmdWord, 8'hFF, 8'h00, 1'b0, '0);
    add_item(CmdWord, 8'h00, 8'hFF, 1'b1, '1);
    add_item(CmdWord, 8'hAA, 8'h55, 1'b0, 64'h8000_0000_0000_0000);
    add_item(CmdWord, 8'h55, 8'hAA, 1'b1, 64'h0000_0000_0000_0001);
    for (int i = 0; i < int'(FragWords) - 4; i++) begin
      add_item(CmdWord, 8'($urandom), 8'($urandom), 1'($urandom), {$urandom, $urandom});
    end
    add_item(CmdStart, '0, '0, 1'b0, '0);
    add_item(CmdRsvd, '0, '0, 1'b0, '0);
    add_item(CmdTimeout, '0, '0, 1'b0, '0);
    add_item(CmdStart, '0, '0, 1'b0, '0);
    add_item(CmdWord, 8'h10, 8'h03, 1'b1, rand_word());
    add_item(CmdWord, 8'h10, 8'h00, 1'b1, rand_word());
    add_item(CmdWord, 8'h10, 8'h00, 1'b0, rand_word());
  endtask

  task automatic write_capacity(input logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CapAddr;
    pwdata  <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    capacity = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'h0, value}) begin
      errors++;
      if (errors <= 10) $display("capacity readback: expected %h actual %h", value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (words_to_send.size() > 0 || in_valid_i || results_due.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: write_capacity(16'd0);
          2: write_capacity(16'd64);
          3: write_capacity(16'd127);
          4: write_capacity(16'd200);
          5: write_capacity(16'($urandom_range(0, 1000)));
          default: write_capacity(16'hFFFF);
        endcase
      end
      @(negedge clk_i);
      idle_en      = (p != NumPhases - 1);
      send_gap_pct = (p == 1 || !idle_en) ? 0 : $urandom_range(5, 30);
      recv_gap_pct = (p == 1 || !idle_en) ? 0 : $urandom_range(5, 30);
      items_queued = 0;
      if (p == 0) queue_directed();
      // hold the receiver off so the result queue fills and input stalls
      if (p == 4) rx_hold = LongHold;
      while (items_queued < PhaseItems) begin
        if ($urandom_range(0, 99) < 85) begin
          send_message(($urandom_range(0, 7) == 0) ? 12 : 4);
        end else begin
          send_noise($urandom_range(1, 4));
        end
      end
    end
    wait_idle();
    if (errors == 0) begin
      $display("fragment_reassembler_unit regression: pass");
    end else begin
      $display("fragment_reassembler_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
